### sv/sfs_pkg.sv
package sfs_pkg;

   localparam int NUM_CLASSES_DEF = 8;
   localparam int MAX_SERVERS_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 256;
   localparam logic [5:0] SERVER_COUNT_RST = 6'd32;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_SHIFT  = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;

   typedef struct packed {
      logic        action;
      logic [2:0]  job_class;
      logic [5:0]  job_size;
      logic [31:0] job_id;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [31:0] entry_id;
      logic [2:0]  entry_class;
      logic [5:0]  entry_size;
      logic        running;
      logic        last;
      logic [5:0]  free_servers;
      logic [8:0]  waiting_count;
      logic [31:0] fifo_violations;
      logic [8:0]  class_running_count;
      logic [8:0]  class_idle_count;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [2:0]  cls;
      logic [5:0]  size;
      logic        run;
   } job_type;

   typedef struct packed {
      logic [1:0] op;
      job_type    data;
   } cell_ctl_type;

   function automatic logic [8:0] inc_sat9(input logic [8:0] x);
      inc_sat9 = (x == 9'h1FF) ? x : x + 9'd1;
   endfunction

   function automatic logic [8:0] dec_floor9(input logic [8:0] x);
      dec_floor9 = (x == 9'd0) ? x : x - 9'd1;
   endfunction

   function automatic logic [8:0] sat_add9(input logic [8:0] a, input logic [8:0] b);
      logic [9:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add9 = s[9] ? 9'h1FF : s[8:0];
   endfunction

endpackage

### sv/sfs_cell.sv
module sfs_cell import sfs_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         app_sel,
   input  logic         live,
   input  logic         left_ge,
   input  job_type      left_job,
   input  job_type      right_job,
   output job_type      job,
   output logic         ge
);

   job_type job_ff, job_in;

   // entry stays ahead of a new job of equal or smaller need
   assign ge  = live && (ctl.data.size <= job_ff.size);
   assign job = job_ff;

   always_comb begin
      case (ctl.op)
         CELL_HOLD:   job_in = job_ff;
         CELL_SHIFT:  job_in = app_sel ? ctl.data : right_job;
         CELL_INSERT: job_in = ge ? job_ff : (left_ge ? ctl.data : left_job);
         default:     job_in = job_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

### sv/server_filling_scheduler.sv
// Sequence: a dropped arrival or an arrival with no idle servers gives a single result without
// an entry; a departure first walks the F0 set entries, and gives a single such result when
// its id is unknown. A rescheduling event folds running counts into idle counts, moves M jobs
// from the queue into the sorted set, walks the F set entries to place what fits, then gives
// one result per cycle for each entry while the receiver is ready.
// Throughput: one event at a time; the next request is taken once the last result is held.
// Reset: synchronous, clears queue, service set and counters; server count returns to 32.
module server_filling_scheduler import sfs_pkg::*; #(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF,
   parameter int MAX_SERVERS = MAX_SERVERS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SW = $clog2(MAX_SERVERS + 1);
   localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [6:0] IDLE_RST = (MAX_SERVERS < 32) ? 7'(MAX_SERVERS) : 7'd32;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DEP    = 3'd1; // walk the set, drop departing entries
   localparam logic [2:0] ST_MERGE  = 3'd2; // fold running counts into idle counts
   localparam logic [2:0] ST_POP    = 3'd3; // take next queue head if need allows
   localparam logic [2:0] ST_INS    = 3'd4; // sorted insert of the popped job
   localparam logic [2:0] ST_GREEDY = 3'd5; // walk the set, place what fits
   localparam logic [2:0] ST_EMIT   = 3'd6; // walk the set, one result per entry
   localparam logic [2:0] ST_NOENT  = 3'd7; // single result without entry

   logic [2:0]    state_ff, state_in;
   logic [5:0]    srv_ff, srv_in;
   job_type       ev_ff, ev_in;
   logic          ovf_ff, ovf_in;
   logic          found_ff, found_in;
   logic [QA-1:0] qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [QW-1:0] qfill_ff, qfill_in;
   logic [SW-1:0] set_fill_ff, set_fill_in, len_ff, len_in, step_ff, step_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [6:0]    need_ff, need_in, idle_ff, idle_in;
   logic [31:0]   vio_ff, vio_in;
   logic [8:0]    run_cnt_ff [NUM_CLASSES];
   logic [8:0]    run_cnt_in [NUM_CLASSES];
   logic [8:0]    idle_cnt_ff [NUM_CLASSES];
   logic [8:0]    idle_cnt_in [NUM_CLASSES];
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // waiting queue storage
   job_type       qmem [QUEUE_DEPTH];
   job_type       qrd_ff;
   logic          q_we, q_re;

   // chain wiring
   cell_ctl_type  ctl;
   logic          app_en;
   logic [SW-1:0] app_idx;
   job_type       cell_job [MAX_SERVERS];
   logic [MAX_SERVERS-1:0] ge, left_ge, live, app_sel;
   logic [SW-1:0] ins_pos;

   job_type       head, new_job;
   logic [CW-1:0] hc, nc;
   logic [6:0]    eff;
   logic          out_free, accept;
   logic [7:0]    idle_sum;
   logic [32:0]   vio_sum;

   assign head = cell_job[0];
   assign hc   = CW'(head.cls);

   // server count in use: zero means one, capped at the server pool
   always_comb begin
      if (srv_ff == 6'd0) begin
         eff = 7'd1;
      end else if (7'(srv_ff) > 7'(MAX_SERVERS)) begin
         eff = 7'(MAX_SERVERS);
      end else begin
         eff = 7'(srv_ff);
      end
   end

   // normalize the incoming request: clamp class, zero size means one
   always_comb begin
      new_job.id   = req_data.job_id;
      new_job.cls  = (32'(req_data.job_class) >= NUM_CLASSES) ? 3'(NUM_CLASSES - 1)
                                                               : req_data.job_class;
      new_job.size = (req_data.job_size == 6'd0) ? 6'd1 : req_data.job_size;
      new_job.run  = 1'b0;
   end
   assign nc = CW'(new_job.cls);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration port: single register at offset zero
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {26'd0, srv_ff} : 32'd0;

   // chain of service set cells, entry 0 is the head
   for (genvar k = 0; k < MAX_SERVERS; k++) begin : g_cell
      assign live[k]    = (SW'(k) < set_fill_ff);
      assign app_sel[k] = app_en && (SW'(k) == app_idx);
      if (k == 0) begin : g_first
         assign left_ge[k] = 1'b1;
      end else begin : g_rest
         assign left_ge[k] = ge[k-1];
      end
      sfs_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .app_sel   (app_sel[k]),
         .live      (live[k]),
         .left_ge   (left_ge[k]),
         .left_job  (cell_job[(k == 0) ? 0 : k - 1]),
         .right_job (cell_job[(k == MAX_SERVERS - 1) ? k : k + 1]),
         .job       (cell_job[k]),
         .ge        (ge[k])
      );
   end

   // insertion place: the one cell where the run of larger-or-equal entries ends
   always_comb begin
      ins_pos = '0;
      for (int k = 0; k < MAX_SERVERS; k++) begin
         if (!ge[k] && left_ge[k]) begin
            ins_pos = ins_pos | SW'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      srv_in       = srv_ff;
      ev_in        = ev_ff;
      ovf_in       = ovf_ff;
      found_in     = found_ff;
      qhead_in     = qhead_ff;
      qtail_in     = qtail_ff;
      qfill_in     = qfill_ff;
      set_fill_in  = set_fill_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      need_in      = need_ff;
      idle_in      = idle_ff;
      vio_in       = vio_ff;
      run_cnt_in   = run_cnt_ff;
      idle_cnt_in  = idle_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_we         = 1'b0;
      q_re         = 1'b0;
      ctl.op       = CELL_HOLD;
      ctl.data     = head;
      app_en       = 1'b0;
      app_idx      = set_fill_ff - SW'(1);
      idle_sum     = 8'(idle_ff) + 8'(head.size);
      vio_sum      = {1'b0, vio_ff} + 33'(pos_ff);

      if (psel && penable && pwrite && pready) begin
         srv_in = pwdata[5:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ev_in  = new_job;
               ovf_in = 1'b0;
               if (!req_data.action) begin
                  if (qfill_ff == QW'(QUEUE_DEPTH)) begin
                     // drop the arrival and flag it
                     ovf_in   = 1'b1;
                     state_in = ST_NOENT;
                  end else begin
                     q_we     = 1'b1;
                     qtail_in = (qtail_ff == QA'(QUEUE_DEPTH - 1)) ? '0 : qtail_ff + QA'(1);
                     qfill_in = qfill_ff + QW'(1);
                     idle_cnt_in[nc] = inc_sat9(idle_cnt_ff[nc]);
                     state_in = (idle_ff != 7'd0) ? ST_MERGE : ST_NOENT;
                  end
               end else begin
                  found_in = 1'b0;
                  len_in   = set_fill_ff;
                  step_in  = set_fill_ff;
                  state_in = ST_DEP;
               end
            end
         end

         ST_DEP: begin
            if (step_ff == '0) begin
               set_fill_in = len_ff;
               state_in    = found_ff ? ST_MERGE : ST_NOENT;
            end else begin
               // rotate the head out; keep it by appending at the current tail
               step_in = step_ff - SW'(1);
               ctl.op  = CELL_SHIFT;
               app_idx = len_ff - SW'(1);
               if (head.id == ev_ff.id) begin
                  found_in = 1'b1;
                  len_in   = len_ff - SW'(1);
                  if (head.run) begin
                     run_cnt_in[hc] = dec_floor9(run_cnt_ff[hc]);
                     idle_in = (idle_sum > 8'd127) ? 7'd127 : idle_sum[6:0];
                  end else begin
                     idle_cnt_in[hc] = dec_floor9(idle_cnt_ff[hc]);
                  end
                  need_in = (need_ff >= 7'(head.size)) ? need_ff - 7'(head.size) : 7'd0;
               end else begin
                  app_en = 1'b1;
               end
            end
         end

         ST_MERGE: begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
               idle_cnt_in[c] = sat_add9(idle_cnt_ff[c], run_cnt_ff[c]);
               run_cnt_in[c]  = 9'd0;
            end
            pos_in   = '0;
            state_in = ST_POP;
         end

         ST_POP: begin
            // account places jumped by the previous insert
            vio_in = vio_sum[32] ? 32'hFFFF_FFFF : vio_sum[31:0];
            pos_in = '0;
            if ((need_ff < eff) && (qfill_ff != '0) && (set_fill_ff < SW'(MAX_SERVERS))) begin
               q_re     = 1'b1;
               qhead_in = (qhead_ff == QA'(QUEUE_DEPTH - 1)) ? '0 : qhead_ff + QA'(1);
               qfill_in = qfill_ff - QW'(1);
               state_in = ST_INS;
            end else begin
               idle_in  = eff;
               step_in  = set_fill_ff;
               state_in = ST_GREEDY;
            end
         end

         ST_INS: begin
            ctl.op      = CELL_INSERT;
            ctl.data    = qrd_ff;
            pos_in      = ins_pos;
            set_fill_in = set_fill_ff + SW'(1);
            need_in     = need_ff + 7'(qrd_ff.size);
            state_in    = ST_POP;
         end

         ST_GREEDY: begin
            if (step_ff == '0) begin
               step_in  = set_fill_ff;
               state_in = (set_fill_ff == '0) ? ST_NOENT : ST_EMIT;
            end else begin
               step_in  = step_ff - SW'(1);
               ctl.op   = CELL_SHIFT;
               app_en   = 1'b1;
               ctl.data.run = (7'(head.size) <= idle_ff);
               if (7'(head.size) <= idle_ff) begin
                  idle_in         = idle_ff - 7'(head.size);
                  run_cnt_in[hc]  = inc_sat9(run_cnt_ff[hc]);
                  idle_cnt_in[hc] = dec_floor9(idle_cnt_ff[hc]);
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_in.entry_valid         = 1'b1;
               rsp_in.entry_id            = head.id;
               rsp_in.entry_class         = head.cls;
               rsp_in.entry_size          = head.size;
               rsp_in.running             = head.run;
               rsp_in.last                = (step_ff == SW'(1));
               rsp_in.free_servers        = idle_ff[5:0];
               rsp_in.waiting_count       = 9'(qfill_ff);
               rsp_in.fifo_violations     = vio_ff;
               rsp_in.class_running_count = run_cnt_ff[hc];
               rsp_in.class_idle_count    = idle_cnt_ff[hc];
               rsp_in.overflow            = 1'b0;
               ctl.op   = CELL_SHIFT;
               app_en   = 1'b1;
               step_in  = step_ff - SW'(1);
               if (step_ff == SW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_NOENT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_in.entry_valid         = 1'b0;
               rsp_in.entry_id            = 32'd0;
               rsp_in.entry_class         = 3'd0;
               rsp_in.entry_size          = 6'd0;
               rsp_in.running             = 1'b0;
               rsp_in.last                = 1'b1;
               rsp_in.free_servers        = idle_ff[5:0];
               rsp_in.waiting_count       = 9'(qfill_ff);
               rsp_in.fifo_violations     = vio_ff;
               rsp_in.class_running_count = 9'd0;
               rsp_in.class_idle_count    = 9'd0;
               rsp_in.overflow            = ovf_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         srv_ff       <= SERVER_COUNT_RST;
         ovf_ff       <= 1'b0;
         found_ff     <= 1'b0;
         qhead_ff     <= '0;
         qtail_ff     <= '0;
         qfill_ff     <= '0;
         set_fill_ff  <= '0;
         len_ff       <= '0;
         step_ff      <= '0;
         pos_ff       <= '0;
         need_ff      <= 7'd0;
         idle_ff      <= IDLE_RST;
         vio_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            run_cnt_ff[c]  <= 9'd0;
            idle_cnt_ff[c] <= 9'd0;
         end
      end else begin
         state_ff     <= state_in;
         srv_ff       <= srv_in;
         ovf_ff       <= ovf_in;
         found_ff     <= found_in;
         qhead_ff     <= qhead_in;
         qtail_ff     <= qtail_in;
         qfill_ff     <= qfill_in;
         set_fill_ff  <= set_fill_in;
         len_ff       <= len_in;
         step_ff      <= step_in;
         pos_ff       <= pos_in;
         need_ff      <= need_in;
         idle_ff      <= idle_in;
         vio_ff       <= vio_in;
         rsp_valid_ff <= rsp_valid_in;
         run_cnt_ff   <= run_cnt_in;
         idle_cnt_ff  <= idle_cnt_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      ev_ff  <= ev_in;
      rsp_ff <= rsp_in;
   end

   // waiting queue: write at tail on arrival, registered read at head
   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem[qtail_ff] <= new_job;
      end
      if (q_re) begin
         qrd_ff <= qmem[qhead_ff];
      end
   end

endmodule

### dv/tb.sv
module tb;
   import sfs_pkg::*;

   localparam logic [1:0] SERVER_COUNT_ADDR = 2'd0;
   localparam bit ARRIVE = 1'b0;
   localparam bit DEPART = 1'b1;
   // worst reschedule pass: full chain walk plus queue moves
   localparam int SETTLE_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   server_filling_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Scheduler mirror: queue, sorted service set, counters
   // ---------------------------------------------------------------
   int unsigned srv_reg = 32;
   job_type     wait_q [256];
   int          q_head = 0;
   int          wait_fill = 0;
   job_type     svc_set [32];
   int          svc_fill = 0;
   int          svc_need = 0;
   int          idle_srv = 32;
   int unsigned cls_run [8];
   int unsigned cls_idle [8];
   logic [31:0] jump_total = '0;

   rsp_type sched_due [$];   // results still owed by the block
   int      errors = 0;
   int      rsp_seen = 0;
   int      overflow_seen = 0;
   int      rsp_hold = 0;     // forced receiver hold-off, in cycles
   bit      quiet = 1'b0;     // no idling on either side

   // append one owed result at the tail
   function automatic void owe(rsp_type x);
      sched_due.insert(sched_due.size(), x);
   endfunction

   function automatic int servers_in_use();
      int s;
      s = srv_reg & 63;
      if (s == 0) s = 1;
      if (s > 32) s = 32;
      return s;
   endfunction

   function automatic rsp_type make_rsp(bit has, job_type e, bit is_last, bit ovf);
      rsp_type o;
      o = '0;
      o.entry_valid = has;
      if (has) begin
         o.entry_id = e.id;
         o.entry_class = e.cls;
         o.entry_size = e.size;
         o.running = e.run;
         o.class_running_count = cls_run[e.cls][8:0];
         o.class_idle_count = cls_idle[e.cls][8:0];
      end
      o.last = is_last;
      o.free_servers = idle_srv[5:0];
      o.waiting_count = wait_fill[8:0];
      o.fifo_violations = jump_total;
      o.overflow = ovf;
      return o;
   endfunction

   task automatic refill_servers();
      int eff, c, k, pos;
      job_type j;
      eff = servers_in_use();
      // everything stops, then the greedy pass restarts what fits
      for (c = 0; c < 8; c++) begin
         cls_idle[c] += cls_run[c];
         if (cls_idle[c] > 511) cls_idle[c] = 511;
         cls_run[c] = 0;
      end
      while (svc_need < eff && wait_fill > 0 && svc_fill < 32) begin
         j = wait_q[q_head];
         q_head = (q_head + 1) % 256;
         wait_fill--;
         pos = 0;
         while (pos < svc_fill && j.size <= svc_set[pos].size) pos++;
         if (32'hFFFF_FFFF - jump_total < pos) jump_total = 32'hFFFF_FFFF;
         else jump_total += pos;
         for (k = svc_fill; k > pos; k--) svc_set[k] = svc_set[k-1];
         svc_set[pos] = j;
         svc_fill++;
         svc_need += j.size;
      end
      idle_srv = eff;
      for (k = 0; k < svc_fill; k++) begin
         if (svc_set[k].size <= idle_srv) begin
            svc_set[k].run = 1'b1;
            if (cls_run[svc_set[k].cls] < 511) cls_run[svc_set[k].cls]++;
            if (cls_idle[svc_set[k].cls] > 0) cls_idle[svc_set[k].cls]--;
            idle_srv -= svc_set[k].size;
         end else begin
            svc_set[k].run = 1'b0;
         end
      end
   endtask

   task automatic schedule_event(req_type r);
      job_type j, e;
      bit filled, found;
      int w, k;
      filled = 1'b0;
      found = 1'b0;
      j.id = r.job_id;
      j.cls = r.job_class;
      j.size = (r.job_size == 0) ? 6'd1 : r.job_size;
      j.run = 1'b0;
      if (r.action == ARRIVE) begin
         if (wait_fill >= 256) begin
            owe(make_rsp(1'b0, j, 1'b1, 1'b1));
            return;
         end
         wait_q[(q_head + wait_fill) % 256] = j;
         wait_fill++;
         if (cls_idle[j.cls] < 511) cls_idle[j.cls]++;
         if (idle_srv > 0) begin
            refill_servers();
            filled = 1'b1;
         end
      end else begin
         w = 0;
         for (k = 0; k < svc_fill; k++) begin
            e = svc_set[k];
            if (e.id == j.id) begin
               found = 1'b1;
               if (e.run) begin
                  if (cls_run[e.cls] > 0) cls_run[e.cls]--;
               end else if (cls_idle[e.cls] > 0) begin
                  cls_idle[e.cls]--;
               end
               svc_need = (svc_need >= e.size) ? svc_need - e.size : 0;
               if (e.run) begin
                  idle_srv += e.size;
                  if (idle_srv > 127) idle_srv = 127;
               end
            end else begin
               svc_set[w] = e;
               w++;
            end
         end
         svc_fill = w;
         if (found) begin
            refill_servers();
            filled = 1'b1;
         end
      end
      if (!filled || svc_fill == 0) begin
         owe(make_rsp(1'b0, j, 1'b1, 1'b0));
         return;
      end
      for (k = 0; k < svc_fill; k++)
         owe(make_rsp(1'b1, svc_set[k], k + 1 == svc_fill, 1'b0));
   endtask

   // ---------------------------------------------------------------
   // Gaps: mostly none, some short, a few long
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random stalls plus the forced hold-off
   initial begin : drain_side
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            stall = pick_gap();
            rsp_ready <= (stall == 0);
         end
      end
   end

   // compare each accepted result with the oldest one owed
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (rsp_data.overflow) overflow_seen++;
         if (sched_due.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            errors++;
         end else begin
            want = sched_due.pop_front();
            if (rsp_data.entry_valid !== want.entry_valid) begin
               $error("entry_valid exp %0d got %0d", want.entry_valid, rsp_data.entry_valid);
               errors++;
            end
            if (rsp_data.entry_id !== want.entry_id) begin
               $error("entry_id exp %h got %h", want.entry_id, rsp_data.entry_id);
               errors++;
            end
            if (rsp_data.entry_class !== want.entry_class) begin
               $error("entry_class exp %0d got %0d", want.entry_class, rsp_data.entry_class);
               errors++;
            end
            if (rsp_data.entry_size !== want.entry_size) begin
               $error("entry_size exp %0d got %0d", want.entry_size, rsp_data.entry_size);
               errors++;
            end
            if (rsp_data.running !== want.running) begin
               $error("running exp %0d got %0d", want.running, rsp_data.running);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last exp %0d got %0d", want.last, rsp_data.last);
               errors++;
            end
            if (rsp_data.free_servers !== want.free_servers) begin
               $error("free_servers exp %0d got %0d", want.free_servers, rsp_data.free_servers);
               errors++;
            end
            if (rsp_data.waiting_count !== want.waiting_count) begin
               $error("waiting_count exp %0d got %0d", want.waiting_count,
                      rsp_data.waiting_count);
               errors++;
            end
            if (rsp_data.fifo_violations !== want.fifo_violations) begin
               $error("fifo_violations exp %0d got %0d", want.fifo_violations,
                      rsp_data.fifo_violations);
               errors++;
            end
            if (rsp_data.class_running_count !== want.class_running_count) begin
               $error("class_running_count exp %0d got %0d", want.class_running_count,
                      rsp_data.class_running_count);
               errors++;
            end
            if (rsp_data.class_idle_count !== want.class_idle_count) begin
               $error("class_idle_count exp %0d got %0d", want.class_idle_count,
                      rsp_data.class_idle_count);
               errors++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow exp %0d got %0d", want.overflow, rsp_data.overflow);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   int req_sent = 0;

   // offer one request, hold it until taken; typed rows replace the prediction
   task automatic send_request(req_type r, bit typed, rsp_type want);
      int gap, n;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n = sched_due.size();
      schedule_event(r);
      if (typed) begin
         while (sched_due.size() > n) void'(sched_due.pop_back());
         owe(want);
      end
      req_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (sched_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_server_count(logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SERVER_COUNT_ADDR;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      srv_reg = v & 63;
   endtask

   function automatic req_type make_req(bit act, int cls, int sz, logic [31:0] id);
      req_type r;
      r.action = act;
      r.job_class = 3'(cls);
      r.job_size = 6'(sz);
      r.job_id = id;
      return r;
   endfunction

   // arrivals and departures; departures mostly of jobs in service, some stray ids and reused ids
   function automatic req_type random_request();
      req_type r;
      int p;
      r = make_req(ARRIVE, $urandom_range(0, 7), 0, $urandom);
      p = $urandom_range(0, 99);
      if (p < 70) r.job_size = 6'($urandom_range(1, 8));
      else if (p < 78) r.job_size = 6'd0;
      else r.job_size = 6'($urandom_range(9, 63));
      if ($urandom_range(0, 99) < 45) begin
         r.action = DEPART;
         r.job_size = 6'($urandom);
         if (svc_fill > 0 && $urandom_range(0, 99) < 85)
            r.job_id = svc_set[$urandom_range(0, svc_fill - 1)].id;
      end else if (svc_fill > 0 && $urandom_range(0, 99) < 5) begin
         r.job_id = svc_set[$urandom_range(0, svc_fill - 1)].id;
      end
      return r;
   endfunction

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } stim_row;

   stim_row plan [$];

   function automatic void add_row(req_type r, bit typed = 1'b0, rsp_type want = '0);
      stim_row s;
      s.r = r;
      s.typed = typed;
      s.want = want;
      plan.insert(plan.size(), s);
   endfunction

   initial begin : limit
      #20000000;
      $display("FAILURE");
      $finish;
   end

   initial begin : main
      int i, p;
      int unsigned srv_plan [7];
      srv_plan = '{8, 0, 1, 63, 32, 17, 3};

      // after reset: stray departure gives the no-reschedule result
      add_row(make_req(DEPART, 0, 1, 32'd5), 1'b1,
              '{1'b0, 32'd0, 3'd0, 6'd0, 1'b0, 1'b1, 6'd32, 9'd0, 32'd0, 9'd0, 9'd0, 1'b0});
      // one job takes every server
      add_row(make_req(ARRIVE, 0, 32, 32'hFFFF_FFFF), 1'b1,
              '{1'b1, 32'hFFFF_FFFF, 3'd0, 6'd32, 1'b1, 1'b1, 6'd0, 9'd0, 32'd0,
                9'd1, 9'd0, 1'b0});
      // no idle servers: zero-size job just waits
      add_row(make_req(ARRIVE, 7, 0, 32'd1), 1'b1,
              '{1'b0, 32'd0, 3'd0, 6'd0, 1'b0, 1'b1, 6'd0, 9'd1, 32'd0, 9'd0, 9'd0, 1'b0});
      add_row(make_req(DEPART, 3, 9, 32'hFFFF_FFFF));
      add_row(make_req(ARRIVE, 3, 63, 32'd2));        // never fits
      add_row(make_req(ARRIVE, 5, 16, 32'd3));
      add_row(make_req(ARRIVE, 6, 16, 32'd4));        // goes after equal need
      add_row(make_req(ARRIVE, 2, 31, 32'd7));
      add_row(make_req(ARRIVE, 4, 31, 32'd7));        // duplicate id
      add_row(make_req(DEPART, 0, 0, 32'd0));         // unknown id
      add_row(make_req(DEPART, 0, 1, 32'd7));         // both copies still wait in the queue: id not found
      add_row(make_req(DEPART, 1, 63, 32'd2));
      add_row(make_req(ARRIVE, 1, 1, 32'hAAAA_5555));
      add_row(make_req(ARRIVE, 7, 32, 32'h5555_AAAA));
      add_row(make_req(DEPART, 7, 32, 32'd3));
      add_row(make_req(DEPART, 7, 32, 32'd4));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) send_request(plan[i].r, plan[i].typed, plan[i].want);
      settle();

      // random phases over several server counts
      for (p = 0; p < 7; p++) begin
         write_server_count(srv_plan[p]);
         quiet = (p % 3 == 2);
         if (p == 1) rsp_hold = 400;   // block backs up and stalls requests
         for (i = 0; i < 14; i++) send_request(random_request(), 1'b0, '0);
         settle();
      end
      quiet = 1'b0;

      // one server: the queue fills until arrivals are dropped
      write_server_count(1);
      i = 0;
      while (wait_fill < 256 && i < 400) begin
         send_request(make_req(ARRIVE, $urandom_range(0, 7), $urandom_range(1, 4),
                               $urandom), 1'b0, '0);
         i++;
      end
      repeat (3) send_request(make_req(ARRIVE, 7, 63, $urandom), 1'b0, '0);
      if (svc_fill > 0) send_request(make_req(DEPART, 0, 1, svc_set[0].id), 1'b0, '0);
      settle();

      $display("run covered %0d requests, %0d results, %0d dropped arrivals",
               req_sent, rsp_seen, overflow_seen);
      $display("server counts 0..63 exercised, queue filled to its limit");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
sv/sfs_pkg.sv
sv/sfs_cell.sv
sv/server_filling_scheduler.sv
dv/tb.sv
